>>> hdl/ptwa_pkg.sv
package ptwa_pkg;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int MAC_W      = 48;
    localparam int CAP_W      = 32;
    localparam int TIME_W     = 32;
    localparam int SEED_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int SLOT_W     = 4;
    localparam int VCOUNT_W   = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Seed values 0 .. SEED_RANGE-1; slot indices up to 255 widen to EXT_W
    localparam int SEED_RANGE = 1 << SEED_W;
    localparam int EXT_W      = SEED_W + 1;

    localparam int NODE_SLOTS_DEF = 16;

    localparam logic [TIME_W-1:0] TIMEOUT_RST = TIME_W'(5000);
    localparam logic [CAP_W-1:0]  OWN_CAP_RST = '0;

    typedef enum logic [CMD_W-1:0] {
        CMD_ANNOUNCE = 2'd0,
        CMD_QUERY    = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_PICK     = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMEOUT = 1'd0,
        REG_OWN_CAP = 1'd1
    } t_reg_idx;

    // One table entry as held in the RAM
    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [CAP_W-1:0]  capacity;
        logic [TIME_W-1:0] seen_time;
    } t_entry;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [SLOT_W-1:0]      slot;
        logic [SEED_W-1:0]      next_seed;
        logic                   reply_needed;
        logic [MAC_W-1:0]       reply_mac;
        logic signed [CAP_W-1:0] reply_capacity;
        logic [VCOUNT_W-1:0]    valid_count;
    } t_result;

    // Controller -> datapath
    typedef struct packed {
        logic accept;
        logic scan_step;
        logic pick_step;
        logic write;
        logic load_out;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        t_cmd cmd;
        logic last_step;
        logic pick_hit;
        logic out_free;
    } t_dp_stat;

endpackage

>>> hdl/ptwa_in_if.sv
interface ptwa_in_if import ptwa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [MAC_W-1:0]         src_mac;
    logic signed [CAP_W-1:0]  peer_capacity;
    logic [TIME_W-1:0]        now_ms;
    logic [SEED_W-1:0]        seed_in;

    modport source (
        output valid, cmd, src_mac, peer_capacity, now_ms, seed_in,
        input  ready
    );
    modport sink (
        input  valid, cmd, src_mac, peer_capacity, now_ms, seed_in,
        output ready
    );
endinterface

>>> hdl/ptwa_out_if.sv
interface ptwa_out_if import ptwa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic [SLOT_W-1:0]        slot;
    logic [SEED_W-1:0]        next_seed;
    logic                     reply_needed;
    logic [MAC_W-1:0]         reply_mac;
    logic signed [CAP_W-1:0]  reply_capacity;
    logic [VCOUNT_W-1:0]      valid_count;

    modport source (
        output valid, status, slot, next_seed, reply_needed, reply_mac,
               reply_capacity, valid_count,
        input  ready
    );
    modport sink (
        input  valid, status, slot, next_seed, reply_needed, reply_mac,
               reply_capacity, valid_count,
        output ready
    );
endinterface

>>> hdl/ptwa_ram.sv
module ptwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [ADDR_W-1:0]        i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [ADDR_W-1:0]        i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/ptwa_ctrl.sv
module ptwa_ctrl import ptwa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_in_cmd,
    output logic             o_in_ready,
    input  t_dp_stat         i_st,
    output t_dp_cmd          o_ctl
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DRAIN = 6'b000100,
        S_WRITE = 6'b001000,
        S_PICK  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.accept = 1'b1;
                    unique case (t_cmd'(i_in_cmd))
                        CMD_ANNOUNCE, CMD_TICK: n_state = S_SCAN;
                        CMD_QUERY:              n_state = S_OUT;
                        CMD_PICK:               n_state = S_PICK;
                        default:                n_state = S_OUT;
                    endcase
                end
            end
            S_SCAN: begin
                o_ctl.scan_step = 1'b1;
                if (i_st.last_step) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = (i_st.cmd == CMD_ANNOUNCE) ? S_WRITE : S_OUT;
            end
            S_WRITE: begin
                o_ctl.write = 1'b1;
                n_state     = S_OUT;
            end
            S_PICK: begin
                o_ctl.pick_step = 1'b1;
                if (i_st.pick_hit || i_st.last_step) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_st.out_free) begin
                    o_ctl.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

`ifndef ASSERT_OFF
    a_query_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.accept && (i_in_cmd == CMD_QUERY)) |=> (r_state == S_OUT))
        else $error("query did not go straight to output");
    a_write_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> ($past(r_state) == S_DRAIN))
        else $error("write state entered without a completed scan");
`endif
endmodule

>>> hdl/ptwa_dp.sv
module ptwa_dp import ptwa_pkg::*; #(
    parameter int NODE_SLOTS = NODE_SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [CMD_W-1:0]         i_item_cmd,
    input  logic [MAC_W-1:0]         i_item_mac,
    input  logic signed [CAP_W-1:0]  i_item_cap,
    input  logic [TIME_W-1:0]        i_item_now,
    input  logic [SEED_W-1:0]        i_item_seed,
    input  t_dp_cmd                  i_ctl,
    output t_dp_stat                 o_st,
    output t_result                  o_res,
    output logic                     o_res_valid,
    input  logic                     i_res_ready
);
    localparam int IDX_W = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
    localparam int CNT_W = $clog2(NODE_SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NODE_SLOTS - 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NODE_SLOTS - 1);
    localparam int ENTRY_W = $bits(t_entry);

    // Configuration
    logic [TIME_W-1:0] r_timeout;
    logic [CAP_W-1:0]  r_own_cap;

    // Latched item
    t_cmd               r_cmd;
    logic [MAC_W-1:0]   r_mac;
    logic [CAP_W-1:0]   r_cap;
    logic [TIME_W-1:0]  r_now;
    logic [SEED_W-1:0]  r_seed;

    // Scan state
    logic [IDX_W-1:0]   r_ptr;
    logic [CNT_W-1:0]   r_step;
    logic               r_chk_vld;
    logic [IDX_W-1:0]   r_chk_idx;
    logic               r_hit_found, r_free_found, r_pick_found;
    logic [IDX_W-1:0]   r_hit_idx, r_free_idx;

    // Table control
    logic [NODE_SLOTS-1:0] r_valid;
    logic [CNT_W-1:0]      r_count;

    t_result r_res;
    logic    r_res_vld;

    // seed mod NODE_SLOTS, worked out at elaboration
    logic [IDX_W-1:0] w_start_lut [SEED_RANGE];
    for (genvar s = 0; s < SEED_RANGE; s++) begin : g_start_lut
        localparam int START = s % NODE_SLOTS;
        assign w_start_lut[s] = IDX_W'(START);
    end

    // Entry RAM
    logic             w_we;
    logic [IDX_W-1:0] w_sel_idx;
    t_entry           w_wdata;
    t_entry           w_rdata;
    logic [ENTRY_W-1:0] w_rdata_raw;

    assign w_sel_idx = r_hit_found ? r_hit_idx : r_free_idx;
    assign w_we      = i_ctl.write && (r_hit_found || r_free_found);
    assign w_wdata   = '{mac: r_mac, capacity: r_cap, seen_time: r_now};

    ptwa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NODE_SLOTS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_sel_idx),
        .i_wdata (w_wdata),
        .i_re    (i_ctl.scan_step),
        .i_raddr (r_ptr),
        .o_rdata (w_rdata_raw)
    );
    assign w_rdata = t_entry'(w_rdata_raw);

    // Compare stage, one entry behind the read address
    logic w_chk_valid, w_mac_hit, w_free, w_age_over, w_expire;
    assign w_chk_valid = r_valid[r_chk_idx];
    assign w_mac_hit   = r_chk_vld && w_chk_valid && (w_rdata.mac == r_mac);
    assign w_free      = r_chk_vld && !w_chk_valid;
    // Timestamp ahead of now counts as age zero, which never exceeds the timeout
    assign w_age_over  = (r_now > w_rdata.seen_time) &&
                         ((r_now - w_rdata.seen_time) > r_timeout);
    assign w_expire    = r_chk_vld && w_chk_valid && w_age_over && (r_cmd == CMD_TICK);

    logic [IDX_W-1:0] w_ptr_next;
    assign w_ptr_next = (r_ptr == LAST_IDX) ? '0 : r_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_own_cap <= OWN_CAP_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_TIMEOUT: r_timeout <= i_cfg_data;
                REG_OWN_CAP: r_own_cap <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd  <= t_cmd'(i_item_cmd);
            r_mac  <= i_item_mac;
            r_cap  <= i_item_cap;
            r_now  <= i_item_now;
            r_seed <= i_item_seed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr        <= '0;
            r_step       <= '0;
            r_chk_vld    <= 1'b0;
            r_chk_idx    <= '0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_pick_found <= 1'b0;
            r_hit_idx    <= '0;
            r_free_idx   <= '0;
        end else begin
            r_chk_vld <= i_ctl.scan_step;
            if (i_ctl.accept) begin
                r_ptr        <= (t_cmd'(i_item_cmd) == CMD_PICK) ?
                                w_start_lut[i_item_seed] : '0;
                r_step       <= '0;
                r_hit_found  <= 1'b0;
                r_free_found <= 1'b0;
                r_pick_found <= 1'b0;
            end else if (i_ctl.scan_step) begin
                r_chk_idx <= r_ptr;
                r_ptr     <= r_ptr + 1'b1;
                r_step    <= r_step + 1'b1;
            end else if (i_ctl.pick_step) begin
                if (r_valid[r_ptr]) begin
                    r_pick_found <= 1'b1;
                end else begin
                    r_ptr  <= w_ptr_next;
                    r_step <= r_step + 1'b1;
                end
            end
            if (w_mac_hit && !r_hit_found) begin
                r_hit_found <= 1'b1;
                r_hit_idx   <= r_chk_idx;
            end
            if (w_free && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_chk_idx;
            end
        end
    end

    // Valid bits and their count; an expiry and a write never share a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else begin
            if (w_expire) begin
                r_valid[r_chk_idx] <= 1'b0;
                r_count            <= r_count - 1'b1;
            end else if (w_we) begin
                r_valid[w_sel_idx] <= 1'b1;
                if (!r_hit_found) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    // Result assembly
    logic [EXT_W-1:0] w_sel_ext, w_pick_ext, w_pick_next, w_cnt_ext;
    t_result          w_res;

    assign w_sel_ext   = EXT_W'(w_sel_idx);
    assign w_pick_ext  = EXT_W'(r_ptr);
    assign w_pick_next = w_pick_ext + 1'b1;
    assign w_cnt_ext   = EXT_W'(r_count);

    always_comb begin
        w_res             = '0;
        w_res.status      = ST_OK;
        w_res.next_seed   = r_seed;
        w_res.valid_count = w_cnt_ext[VCOUNT_W-1:0];
        unique case (r_cmd)
            CMD_ANNOUNCE: begin
                if (r_hit_found || r_free_found) begin
                    w_res.slot = w_sel_ext[SLOT_W-1:0];
                end else begin
                    w_res.status = ST_FULL;
                end
            end
            CMD_QUERY: begin
                w_res.reply_needed   = 1'b1;
                w_res.reply_mac      = r_mac;
                w_res.reply_capacity = r_own_cap;
            end
            CMD_TICK: ;
            CMD_PICK: begin
                if (r_pick_found) begin
                    w_res.slot      = w_pick_ext[SLOT_W-1:0];
                    w_res.next_seed = w_pick_next[SEED_W-1:0];
                end else begin
                    w_res.status = ST_EMPTY;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_res <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (i_ctl.load_out) begin
            r_res_vld <= 1'b1;
        end else if (i_res_ready) begin
            r_res_vld <= 1'b0;
        end
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_vld;

    assign o_st.cmd       = r_cmd;
    assign o_st.last_step = (r_step == LAST_STEP);
    assign o_st.pick_hit  = r_valid[r_ptr];
    assign o_st.out_free  = !r_res_vld || i_res_ready;

`ifndef ASSERT_OFF
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_W'($countones(r_valid)))
        else $error("valid count out of step with valid bits");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && !r_hit_found) |-> !r_valid[w_sel_idx])
        else $error("new peer written over a valid entry");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load_out |-> (!r_res_vld || i_res_ready))
        else $error("result register loaded while still occupied");
`endif
endmodule

>>> hdl/peer_table_with_aging.sv
// Peer table with ageing: keeps up to NODE_SLOTS peers keyed by 48-bit MAC.
// One input transaction at a time; each gives exactly one result transaction.
// Announce scans every entry through the entry RAM's single read port, one
// entry a cycle, then writes the matching or else the first free entry, if
// any. Tick uses the same scan and drops entries older than timeout_ms (a
// timestamp ahead of now counts as age zero). Pick walks the valid bits
// round-robin from seed_in mod NODE_SLOTS, one a cycle, stopping at the first
// valid entry. Query goes straight to the output stage without a scan.
// The result sits in an output register, so a finished result may wait on
// o_result.ready while the next transaction is taken; the one after waits
// until that register frees.
// Registers (i_cfg_idx): 0 timeout_ms (reset 5000), 1 own_capacity (reset 0);
// write them only while the block is idle. No clearing pass after reset.
module peer_table_with_aging import ptwa_pkg::*; #(
    parameter int NODE_SLOTS = NODE_SLOTS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    ptwa_in_if.sink                i_item,
    ptwa_out_if.source             o_result
);
    t_dp_cmd  w_ctl;
    t_dp_stat w_st;
    t_result  w_res;
    logic     w_res_valid;

    // Sequencer: owns the input handshake and the scan/pick/write order
    ptwa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_in_cmd   (i_item.cmd),
        .o_in_ready (i_item.ready),
        .i_st       (w_st),
        .o_ctl      (w_ctl)
    );

    // Table storage, compare stage, valid bits and result register
    ptwa_dp #(
        .NODE_SLOTS (NODE_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_item_cmd  (i_item.cmd),
        .i_item_mac  (i_item.src_mac),
        .i_item_cap  (i_item.peer_capacity),
        .i_item_now  (i_item.now_ms),
        .i_item_seed (i_item.seed_in),
        .i_ctl       (w_ctl),
        .o_st        (w_st),
        .o_res       (w_res),
        .o_res_valid (w_res_valid),
        .i_res_ready (o_result.ready)
    );

    assign o_result.valid          = w_res_valid;
    assign o_result.status         = w_res.status;
    assign o_result.slot           = w_res.slot;
    assign o_result.next_seed      = w_res.next_seed;
    assign o_result.reply_needed   = w_res.reply_needed;
    assign o_result.reply_mac      = w_res.reply_mac;
    assign o_result.reply_capacity = w_res.reply_capacity;
    assign o_result.valid_count    = w_res.valid_count;
endmodule

>>> tb/sv/tb_peer_table_with_aging.sv
`timescale 1ns / 1ps

// Peer table testbench. The sender drives transactions in random bursts; a
// mirror of the table, kept here, is updated on every accepted transaction
// and yields the result that the block must return. The receiver stalls on
// a rotating pattern and checks each result against the oldest one awaited.
module tb_peer_table_with_aging;
    import ptwa_pkg::*;

    localparam int SLOTS    = NODE_SLOTS_DEF;
    localparam int MAC_POOL = 24;    // more MACs than slots, so the table fills

    // One input transaction as the sender sees it
    typedef struct packed {
        t_cmd                    cmd;
        logic [MAC_W-1:0]        mac;
        logic signed [CAP_W-1:0] cap;
        logic [TIME_W-1:0]       now;
        logic [SEED_W-1:0]       seed;
    } t_item;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ptwa_in_if  item_if ();
    ptwa_out_if result_if ();

    peer_table_with_aging #(
        .NODE_SLOTS (SLOTS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_if),
        .o_result   (result_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Mirror of the table and its registers
    // ------------------------------------------------------------------
    logic                    peer_valid [SLOTS];
    logic [MAC_W-1:0]        peer_mac   [SLOTS];
    logic signed [CAP_W-1:0] peer_cap   [SLOTS];
    logic [TIME_W-1:0]       peer_seen  [SLOTS];
    logic [TIME_W-1:0]       ageing_limit;
    logic [CAP_W-1:0]        own_cap_reg;

    t_result          awaited_results [$];
    logic [MAC_W-1:0] mac_pool [MAC_POOL];
    logic [TIME_W-1:0] wall_ms;

    int err_cnt    = 0;
    int n_items    = 0;
    int n_results  = 0;
    int n_full     = 0;
    int n_aged     = 0;
    int n_empty    = 0;
    int n_cfg      = 0;
    int burst_left = 0;

    // Receiver stall pattern: rotates every cycle, reloaded now and then
    logic [15:0] stall_pat;
    int          stall_age;

    // Applies one transaction to the mirror and returns the result it must give
    function automatic t_result update_peer_table(input t_item it);
        t_result          r;
        int               hit;
        int               start;
        int               j;
        int               cnt;
        logic [TIME_W-1:0] age;

        r           = '0;
        r.next_seed = it.seed;
        hit         = -1;
        case (it.cmd)
            CMD_ANNOUNCE: begin
                // a matching valid entry wins over the first free one
                for (int i = 0; i < SLOTS; i++)
                    if (hit < 0 && peer_valid[i] && peer_mac[i] == it.mac) hit = i;
                for (int i = 0; i < SLOTS; i++)
                    if (hit < 0 && !peer_valid[i]) hit = i;
                if (hit < 0) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    peer_valid[hit] = 1'b1;
                    peer_mac[hit]   = it.mac;
                    peer_cap[hit]   = it.cap;
                    peer_seen[hit]  = it.now;
                    r.slot          = SLOT_W'(hit);
                end
            end
            CMD_QUERY: begin
                r.reply_needed   = 1'b1;
                r.reply_mac      = it.mac;
                r.reply_capacity = own_cap_reg;
            end
            CMD_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (peer_valid[i]) begin
                        // a timestamp ahead of now ages as zero
                        age = (it.now >= peer_seen[i]) ? it.now - peer_seen[i] : '0;
                        if (age > ageing_limit) begin
                            peer_valid[i] = 1'b0;
                            n_aged++;
                        end
                    end
                end
            end
            default: begin
                start = int'(it.seed) % SLOTS;
                for (int k = 0; k < SLOTS; k++) begin
                    j = (start + k) % SLOTS;
                    if (hit < 0 && peer_valid[j]) hit = j;
                end
                if (hit < 0) begin
                    r.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    r.slot      = SLOT_W'(hit);
                    r.next_seed = SEED_W'(hit + 1);
                end
            end
        endcase
        cnt = 0;
        for (int i = 0; i < SLOTS; i++)
            if (peer_valid[i]) cnt++;
        r.valid_count = VCOUNT_W'(cnt);
        return r;
    endfunction

    function automatic t_item make_item(input t_cmd cmd, input logic [MAC_W-1:0] mac,
                                        input logic [CAP_W-1:0] cap,
                                        input logic [TIME_W-1:0] now,
                                        input logic [SEED_W-1:0] seed);
        t_item it;
        it.cmd  = cmd;
        it.mac  = mac;
        it.cap  = cap;
        it.now  = now;
        it.seed = seed;
        return it;
    endfunction

    // Mostly well-formed traffic: MACs drawn from a small pool so that entries
    // are hit, refreshed and aged; time runs forward with the odd wild jump.
    function automatic t_item random_item();
        t_item it;
        int    sel;

        sel = $urandom_range(0, 99);
        if (sel < 45)      it.cmd = CMD_ANNOUNCE;
        else if (sel < 60) it.cmd = CMD_QUERY;
        else if (sel < 80) it.cmd = CMD_TICK;
        else               it.cmd = CMD_PICK;
        if ($urandom_range(0, 6) == 0) it.mac = {16'($urandom), 32'($urandom)};
        else                           it.mac = mac_pool[$urandom_range(0, MAC_POOL - 1)];
        it.cap = $urandom;
        if ($urandom_range(0, 19) == 0) begin
            it.now = $urandom;
        end else begin
            wall_ms = wall_ms + $urandom_range(0, 2500);
            it.now  = wall_ms;
        end
        it.seed = SEED_W'($urandom_range(0, SEED_RANGE - 1));
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Holds the transaction until taken. valid stays high on return so a
    // back-to-back call does not toggle it; the burst logic opens the gaps.
    task automatic send_item(input t_item it);
        int gap;

        item_if.valid         <= 1'b1;
        item_if.cmd           <= it.cmd;
        item_if.src_mac       <= it.mac;
        item_if.peer_capacity <= it.cap;
        item_if.now_ms        <= it.now;
        item_if.seed_in       <= it.seed;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        awaited_results.push_back(update_peer_table(it));
        n_items++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                item_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stop sending and hold off until every awaited result has come back
    task automatic wait_all_results();
        item_if.valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    // Both registers, one write each, only while the block is idle
    task automatic program_regs(input logic [TIME_W-1:0] timeout,
                                input logic [CAP_W-1:0] own_cap);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_TIMEOUT;
        i_cfg_data <= timeout;
        @(posedge i_clk);
        i_cfg_idx  <= REG_OWN_CAP;
        i_cfg_data <= own_cap;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        ageing_limit = timeout;
        own_cap_reg  = own_cap;
        n_cfg += 2;
    endtask

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            err_cnt++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endtask

    task automatic check_result();
        t_result want;

        n_results++;
        if (awaited_results.size() == 0) begin
            err_cnt++;
            $display("%0t: result with no transaction awaiting it: status %0d slot %0d",
                     $time, result_if.status, result_if.slot);
        end else begin
            want = awaited_results.pop_front();
            check_field("status", 64'(want.status), 64'(result_if.status));
            check_field("slot", 64'(want.slot), 64'(result_if.slot));
            check_field("next_seed", 64'(want.next_seed), 64'(result_if.next_seed));
            check_field("reply_needed", 64'(want.reply_needed),
                        64'(result_if.reply_needed));
            check_field("reply_mac", 64'(want.reply_mac), 64'(result_if.reply_mac));
            check_field("reply_capacity", 64'($unsigned(want.reply_capacity)),
                        64'($unsigned(result_if.reply_capacity)));
            check_field("valid_count", 64'(want.valid_count),
                        64'(result_if.valid_count));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
            stall_pat = '1;
            stall_age = 0;
        end else begin
            if (result_if.valid && result_if.ready) check_result();
            if (stall_age == 0) begin
                // free-flowing, random, mostly ready, or mostly stalled
                case ($urandom_range(0, 3))
                    0:       stall_pat = '1;
                    1:       stall_pat = 16'($urandom);
                    2:       stall_pat = 16'($urandom | $urandom);
                    default: stall_pat = 16'($urandom & $urandom) | 16'h0001;
                endcase
                stall_age = 48;
            end
            stall_age--;
            result_if.ready <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[15:1]};
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Straight out of reset: nothing to pick, reply carries the reset capacity
    task automatic test_empty_table();
        send_item(make_item(CMD_PICK, '0, '0, '0, 8'hFF));
        send_item(make_item(CMD_QUERY, '1, '1, '1, 8'h00));
        send_item(make_item(CMD_TICK, '0, '0, '0, 8'h00));
    endtask

    // Sixteen distinct peers, then one too many, then a refresh of an old one.
    // Slot 15 is stamped far in the future so later ticks see it ahead of now.
    task automatic test_fill_to_full();
        logic [CAP_W-1:0]  cap;
        logic [TIME_W-1:0] stamp;

        for (int i = 0; i < SLOTS; i++) begin
            if (i == 0)      cap = 32'h8000_0000;
            else if (i == 1) cap = 32'h7FFF_FFFF;
            else             cap = $urandom;
            stamp = (i == SLOTS - 1) ? '1 : TIME_W'(i * 1000);
            send_item(make_item(CMD_ANNOUNCE, mac_pool[i], cap, stamp, 8'($urandom)));
        end
        send_item(make_item(CMD_ANNOUNCE, mac_pool[SLOTS], $urandom, 32'd20000, 8'h00));
        send_item(make_item(CMD_ANNOUNCE, mac_pool[5], 32'h0000_0000, 32'd9000, 8'h00));
    endtask

    // Seed wraps modulo the slot count
    task automatic test_pick_wrap();
        send_item(make_item(CMD_PICK, '0, '0, '0, 8'hFF));
        send_item(make_item(CMD_PICK, '0, '0, '0, 8'h00));
    endtask

    // Short timeout: old entries go, recent and future-stamped ones stay
    task automatic test_ageing();
        wait_all_results();
        program_regs(32'd1500, own_cap_reg);
        send_item(make_item(CMD_TICK, '0, '0, 32'd10000, 8'h00));
    endtask

    task automatic test_reply_capacity();
        wait_all_results();
        program_regs(ageing_limit, 32'h8000_0000);
        send_item(make_item(CMD_QUERY, 48'h0123_4567_89AB, '0, '0, 8'h00));
    endtask

    task automatic test_random_traffic(input int count, input logic [TIME_W-1:0] timeout,
                                       input logic [CAP_W-1:0] own_cap);
        wait_all_results();
        program_regs(timeout, own_cap);
        for (int k = 0; k < count; k++) begin
            send_item(random_item());
            // let the pipe run dry now and then
            if (k % 150 == 149) wait_all_results();
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = REG_TIMEOUT;
        i_cfg_data            = '0;
        item_if.valid         = 1'b0;
        item_if.cmd           = CMD_ANNOUNCE;
        item_if.src_mac       = '0;
        item_if.peer_capacity = '0;
        item_if.now_ms        = '0;
        item_if.seed_in       = '0;

        for (int i = 0; i < SLOTS; i++) peer_valid[i] = 1'b0;
        ageing_limit = TIMEOUT_RST;
        own_cap_reg  = OWN_CAP_RST;
        wall_ms      = '0;
        for (int i = 0; i < MAC_POOL; i++) mac_pool[i] = {16'($urandom), 32'($urandom)};
        mac_pool[0] = '0;
        mac_pool[1] = '1;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_fill_to_full();
        test_pick_wrap();
        test_ageing();
        test_reply_capacity();
        // timeout extremes first: every entry older than now ages, then nothing ever does
        test_random_traffic(225, '0, 32'h7FFF_FFFF);
        test_random_traffic(225, '1, 32'h8000_0000);
        test_random_traffic(225, TIMEOUT_RST, $urandom);
        test_random_traffic(225, $urandom_range(200, 12000), $urandom);

        wait_all_results();
        repeat (SLOTS + 4) @(posedge i_clk);

        $display("Run covered %0d transactions in, %0d results out, %0d register writes.",
                 n_items, n_results, n_cfg);
        $display("Announces dropped on a full table: %0d, entries aged out: %0d, %s %0d.",
                 n_full, n_aged, "picks on an empty table:", n_empty);
        if (err_cnt == 0) begin
            $display("peer_table_with_aging verification clean");
        end else begin
            $display("peer_table_with_aging verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("peer_table_with_aging verification failed");
        $finish;
    end

endmodule
